/* src/amm3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amm3_pkg
// Shared types, constants and helpers of the adaptive 3x3 mean/median filter.
// ----------------------------------------------------------------------------
package amm3_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned ThrW    = 10;
  localparam int unsigned SumW    = 12;   // nine pixels, up to 2295
  localparam int unsigned Sum3W   = 10;   // three pixels, up to 765
  localparam int unsigned RecipW  = 13;
  localparam int unsigned ProdW   = SumW + RecipW;
  localparam int unsigned RecipSh = 16;

  // floor(x * 7282 / 2^16) equals floor(x / 9) for every x below 2^12
  localparam logic [RecipW-1:0] Recip9 = 13'd7282;
  localparam logic [ThrW-1:0]   DefaultLimit = 10'd30;

  typedef logic [PixW-1:0] pix_t;
  // window order, lowest index first: tl, tm, tr, ml, c, mr, bl, bm, br
  typedef pix_t [8:0] win_t;

  typedef enum logic [1:0] {
    PATH_BORDER = 2'd0,
    PATH_MEAN   = 2'd1,
    PATH_MEDIAN = 2'd2
  } path_e;

  typedef struct packed {
    logic use_mean;
    pix_t mean;
  } mean_dec_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic logic [Sum3W-1:0] absdiff(input logic [Sum3W-1:0] a,
                                               input logic [Sum3W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* src/amm3_mean_contrast.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amm3_mean_contrast
// Directional contrasts against the threshold, and the window mean.
// ----------------------------------------------------------------------------
module amm3_mean_contrast
  import amm3_pkg::*;
(
  input  win_t            win_i,
  input  logic [ThrW-1:0] threshold_i,
  output mean_dec_t       dec_o
);

  logic [Sum3W-1:0] s_left, s_right, s_ul, s_lr, s_top, s_bot, s_ur, s_ll;
  logic [Sum3W-1:0] c_lr, c_diag0, c_tb, c_diag1, c_max01, c_max23, c_max;
  logic [ThrW-1:0]  limit;
  logic [SumW-1:0]  sum9;
  logic [ProdW-1:0] prod;

  function automatic logic [Sum3W-1:0] sum3(input pix_t a, input pix_t b, input pix_t c);
    return Sum3W'(a) + Sum3W'(b) + Sum3W'(c);
  endfunction

  always_comb begin
    s_left  = sum3(win_i[0], win_i[3], win_i[6]);
    s_right = sum3(win_i[2], win_i[5], win_i[8]);
    s_ul    = sum3(win_i[0], win_i[1], win_i[3]);
    s_lr    = sum3(win_i[5], win_i[7], win_i[8]);
    s_top   = sum3(win_i[0], win_i[1], win_i[2]);
    s_bot   = sum3(win_i[6], win_i[7], win_i[8]);
    s_ur    = sum3(win_i[1], win_i[2], win_i[5]);
    s_ll    = sum3(win_i[3], win_i[6], win_i[7]);

    c_lr    = absdiff(s_left, s_right);
    c_diag0 = absdiff(s_ul, s_lr);
    c_tb    = absdiff(s_top, s_bot);
    c_diag1 = absdiff(s_ur, s_ll);
    c_max01 = (c_lr > c_diag0) ? c_lr : c_diag0;
    c_max23 = (c_tb > c_diag1) ? c_tb : c_diag1;
    c_max   = (c_max01 > c_max23) ? c_max01 : c_max23;

    limit   = (threshold_i == '0) ? DefaultLimit : threshold_i;

    // both widths are 10 bits, so the compare needs no extension
    dec_o.use_mean = (ThrW'(c_max) < limit);

    sum9 = SumW'(s_left) + SumW'(s_right) + SumW'(win_i[1]) + SumW'(win_i[4])
         + SumW'(win_i[7]);
    // divide by nine through the reciprocal
    prod = ProdW'(sum9) * ProdW'(Recip9);
    dec_o.mean = prod[RecipSh +: PixW];
  end

endmodule

/* src/amm3_median.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amm3_median
// Median of nine pixels: sort each row, then take the median of the largest row
// minimum, the median of the row medians and the smallest row maximum.
module amm3_median
  import amm3_pkg::*;
(
  input  win_t win_i,
  output pix_t median_o
);

  pix_t row_lo [3];
  pix_t row_md [3];
  pix_t row_hi [3];
  pix_t lo_max, md_med, hi_min;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_lo[r] = min2(min2(win_i[3*r], win_i[3*r+1]), win_i[3*r+2]);
      row_hi[r] = max2(max2(win_i[3*r], win_i[3*r+1]), win_i[3*r+2]);
      row_md[r] = med3(win_i[3*r], win_i[3*r+1], win_i[3*r+2]);
    end
    lo_max   = max2(max2(row_lo[0], row_lo[1]), row_lo[2]);
    hi_min   = min2(min2(row_hi[0], row_hi[1]), row_hi[2]);
    md_med   = med3(row_md[0], row_md[1], row_md[2]);
    median_o = med3(lo_max, md_med, hi_min);
  end

endmodule

/* src/adaptive_mean_median_3x3_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_mean_median_3x3_top
// Adaptive 3x3 filter: window mean on flat areas, median where contrast is high,
// centre passed through on the image border.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction                  | payload
//  s_axis   | in        | tvalid & tready              | tdata 72b window, tuser border
//  m_axis   | out       | tvalid & tready              | tdata pixel, tuser path
//  cfg      | in        | cfg_valid_i (ready always 1) | cfg_data_i threshold
//
//  one window per cycle sustained while m_axis is ready; input register and
//  result register, with the median network and mean multiply between them
//  reset clears both valid flags and sets the threshold to 30
//  a stall on m_axis holds the result; the input register still takes a
//  window while the result register is free or being emptied
// ----------------------------------------------------------------------------
module adaptive_mean_median_3x3_top
  import amm3_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // top_left, top_mid, top_right, mid_left, center, mid_right,
  // bot_left, bot_mid, bot_right (8 bits each, lowest first)
  input  logic [71:0]     s_axis_tdata,
  // on_border
  input  logic            s_axis_tuser,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // pixel_out
  output logic [7:0]      m_axis_tdata,
  // path
  output logic [1:0]      m_axis_tuser,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [ThrW-1:0] cfg_data_i
);

  logic            in_valid_q;
  win_t            win_q;
  logic            border_q;
  logic            out_valid_q;
  pix_t            pix_q;
  path_e           path_q;
  logic [ThrW-1:0] threshold_q;

  logic      out_en, in_en;
  mean_dec_t dec;
  pix_t      median;
  pix_t      pix_d;
  path_e     path_d;

  assign out_en        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_en;
  assign in_en         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= DefaultLimit;
    end else if (cfg_valid_i) begin
      threshold_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en) begin
      win_q    <= s_axis_tdata;
      border_q <= s_axis_tuser;
    end
  end

  amm3_mean_contrast u_mean_contrast (
    .win_i       (win_q),
    .threshold_i (threshold_q),
    .dec_o       (dec)
  );

  amm3_median u_median (
    .win_i    (win_q),
    .median_o (median)
  );

  always_comb begin
    priority if (border_q) begin
      pix_d  = win_q[4];
      path_d = PATH_BORDER;
    end else if (dec.use_mean) begin
      pix_d  = dec.mean;
      path_d = PATH_MEAN;
    end else begin
      pix_d  = median;
      path_d = PATH_MEDIAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && in_valid_q) begin
      pix_q  <= pix_d;
      path_q <= path_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pix_q;
  assign m_axis_tuser  = path_q;

endmodule

/* src/amm3_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amm3_checker
// Port-level checks of the adaptive 3x3 filter, bound to the top level.
// ----------------------------------------------------------------------------
module amm3_checker
  import amm3_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic [71:0]     s_axis_tdata,
  input logic            s_axis_tuser,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [7:0]      m_axis_tdata,
  input logic [1:0]      m_axis_tuser
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_path_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == PATH_BORDER || m_axis_tuser == PATH_MEAN
                       || m_axis_tuser == PATH_MEDIAN))
    else $error("illegal path code");

  // a border window passes both registers to the output when not stalled
  a_border_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser)
      ##1 (!m_axis_tvalid || m_axis_tready)
      |=> m_axis_tvalid && m_axis_tuser == PATH_BORDER
          && m_axis_tdata == $past(s_axis_tdata[39:32], 2))
    else $error("border window not passed through");

endmodule

bind adaptive_mean_median_3x3_top amm3_checker u_amm3_checker (.*);

/* tb/adaptive_mean_median_3x3_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_mean_median_3x3_top_tb
// Self-checking bench for the adaptive 3x3 filter. Windows go in on s_axis
// and a scoreboard predicts each filtered pixel and path from its own copy of
// the threshold. A directed table comes first and is run at the reset
// threshold and at threshold zero. Random phases at various thresholds
// follow, with idle bursts on both sides, one long output stall and one
// drain pause.
// ----------------------------------------------------------------------------
module adaptive_mean_median_3x3_top_tb;
  import amm3_pkg::*;

  localparam int unsigned FallbackLimit = 30;
  localparam int unsigned WinSize       = 9;
  localparam int unsigned PhaseItems    = 155;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned CycleLimit    = 300000;

  typedef struct packed {
    pix_t  px;
    path_e path;
  } filt_res_t;

  typedef struct {
    win_t      win;
    logic      border;
    bit        typed;
    filt_res_t res;
  } stim_row_t;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [71:0]     s_axis_tdata  = '0;
  logic            s_axis_tuser  = 1'b0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [7:0]      m_axis_tdata;
  logic [1:0]      m_axis_tuser;
  logic            cfg_valid_i   = 1'b0;
  logic            cfg_ready_o;
  logic [ThrW-1:0] cfg_data_i    = '0;

  filt_res_t       expected_pix_q [$];
  stim_row_t       stim_table [$];
  logic [ThrW-1:0] limit_reg;
  int unsigned     mismatch_cnt  = 0;
  int unsigned     cycle_cnt     = 0;
  bit              idle_en       = 1'b1;
  bit              sink_hold_req = 1'b0;

  adaptive_mean_median_3x3_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic win_t mk_win(input pix_t tl, input pix_t tm, input pix_t tr,
                                  input pix_t ml, input pix_t c, input pix_t mr,
                                  input pix_t bl, input pix_t bm, input pix_t br);
    return {br, bm, bl, mr, c, ml, tr, tm, tl};
  endfunction

  function automatic int unsigned span(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // expected pixel and path for one window at threshold thr
  function automatic filt_res_t filter_window(input win_t w, input logic border,
                                              input logic [ThrW-1:0] thr);
    int unsigned px [WinSize];
    int unsigned peak, c, lim, acc, nlow, neq;
    filt_res_t   r;
    for (int i = 0; i < WinSize; i++) px[i] = w[i];
    if (border) begin
      r.px   = w[4];
      r.path = PATH_BORDER;
      return r;
    end
    peak = span(px[0] + px[3] + px[6], px[2] + px[5] + px[8]);
    c = span(px[0] + px[1] + px[3], px[5] + px[7] + px[8]);
    if (c > peak) peak = c;
    c = span(px[0] + px[1] + px[2], px[6] + px[7] + px[8]);
    if (c > peak) peak = c;
    c = span(px[1] + px[2] + px[5], px[3] + px[6] + px[7]);
    if (c > peak) peak = c;
    lim = (thr == '0) ? FallbackLimit : thr;
    if (peak < lim) begin
      acc = 0;
      for (int i = 0; i < WinSize; i++) acc += px[i];
      r.px   = pix_t'(acc / WinSize);
      r.path = PATH_MEAN;
    end else begin
      // median by rank: at most four below it and at least five up to it
      r.px   = '0;
      r.path = PATH_MEDIAN;
      for (int i = 0; i < WinSize; i++) begin
        nlow = 0;
        neq  = 0;
        for (int j = 0; j < WinSize; j++) begin
          if (px[j] < px[i]) nlow++;
          else if (px[j] == px[i]) neq++;
        end
        if (nlow <= 4 && nlow + neq >= 5) r.px = pix_t'(px[i]);
      end
    end
    return r;
  endfunction

  function automatic pix_t clip_pix(input int unsigned v);
    return (v > 255) ? pix_t'(255) : pix_t'(v);
  endfunction

  // flat, fully random, saturated or split along one direction
  function automatic win_t random_window();
    win_t        w;
    int unsigned base, spread, lo, hi, dir, r, c;
    bit          sel;
    case ($urandom_range(0, 3))
      0: begin
        base   = $urandom_range(0, 255);
        spread = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 12);
        for (int i = 0; i < WinSize; i++) w[i] = clip_pix(base + $urandom_range(0, spread));
      end
      1: begin
        for (int i = 0; i < WinSize; i++) w[i] = pix_t'($urandom_range(0, 255));
      end
      2: begin
        for (int i = 0; i < WinSize; i++) w[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      default: begin
        lo  = $urandom_range(0, 127);
        hi  = $urandom_range(128, 255);
        dir = $urandom_range(0, 3);
        for (int i = 0; i < WinSize; i++) begin
          r = i / 3;
          c = i % 3;
          case (dir)
            0:       sel = (c == 0);
            1:       sel = (r == 0);
            2:       sel = (r + c < 2);
            default: sel = (c == 2);
          endcase
          w[i] = clip_pix((sel ? hi : lo) + $urandom_range(0, 3));
        end
      end
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic add_row(input win_t w, input logic b, input bit typed,
                         input pix_t px, input path_e path);
    stim_row_t row;
    row.win      = w;
    row.border   = b;
    row.typed    = typed;
    row.res.px   = px;
    row.res.path = path;
    stim_table.push_back(row);
  endtask

  task automatic source_gap();
    if (idle_en && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // offer one window, record its expectation once the transaction completes
  task automatic push_window(input win_t w, input logic b, input filt_res_t res);
    s_axis_tdata  <= w;
    s_axis_tuser  <= b;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pix_q.push_back(res);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_pix_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ThrW-1:0] thr);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_data_i  <= thr;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_reg = thr;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_table();
    filt_res_t res;
    foreach (stim_table[i]) begin
      source_gap();
      res = stim_table[i].typed ? stim_table[i].res
                                : filter_window(stim_table[i].win, stim_table[i].border,
                                                limit_reg);
      push_window(stim_table[i].win, stim_table[i].border, res);
    end
  endtask

  // result side: random back-pressure, plus one long hold on request
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        sink_hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    filt_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pix_q.size() == 0) begin
        report_mismatch($sformatf("result px=%02h path=%0d with nothing pending",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = expected_pix_q.pop_front();
        if (m_axis_tdata !== want.px)
          report_mismatch($sformatf("pixel_out %02h, want %02h", m_axis_tdata, want.px));
        if (m_axis_tuser !== want.path)
          report_mismatch($sformatf("path %0d, want %0d", m_axis_tuser, want.path));
      end
    end
  end

  initial begin
    logic [ThrW-1:0] phase_thr [8];
    win_t            w;
    logic            b;
    limit_reg = ThrW'(FallbackLimit);

    add_row(mk_win(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b1, 8'h00, PATH_MEAN);
    add_row(mk_win(255, 255, 255, 255, 255, 255, 255, 255, 255), 1'b0, 1'b1, 8'hFF,
            PATH_MEAN);
    // border windows ignore everything but the centre
    add_row(mk_win(0, 0, 0, 0, 8'hAB, 0, 0, 0, 0), 1'b1, 1'b1, 8'hAB, PATH_BORDER);
    add_row(mk_win(255, 255, 255, 255, 0, 255, 255, 255, 255), 1'b1, 1'b1, 8'h00,
            PATH_BORDER);
    add_row(mk_win(255, 255, 255, 255, 255, 255, 255, 255, 255), 1'b1, 1'b1, 8'hFF,
            PATH_BORDER);
    // saturated edges along columns, rows and the upper-left diagonal: full contrast, median
    add_row(mk_win(255, 0, 0, 255, 0, 0, 255, 0, 0), 1'b0, 1'b1, 8'h00, PATH_MEDIAN);
    add_row(mk_win(0, 0, 255, 0, 0, 255, 0, 0, 255), 1'b0, 1'b1, 8'h00, PATH_MEDIAN);
    add_row(mk_win(255, 255, 255, 0, 0, 0, 0, 0, 0), 1'b0, 1'b1, 8'h00, PATH_MEDIAN);
    add_row(mk_win(0, 0, 0, 0, 0, 0, 255, 255, 255), 1'b0, 1'b1, 8'h00, PATH_MEDIAN);
    add_row(mk_win(255, 255, 0, 255, 0, 0, 0, 0, 0), 1'b0, 1'b1, 8'h00, PATH_MEDIAN);
    add_row(mk_win(0, 255, 255, 0, 255, 255, 0, 255, 255), 1'b0, 1'b1, 8'hFF, PATH_MEDIAN);
    // contrast just under, at and over the default limit
    add_row(mk_win(29, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b1, 8'h03, PATH_MEAN);
    add_row(mk_win(30, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b1, 8'h00, PATH_MEDIAN);
    add_row(mk_win(31, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, 1'b1, 8'h00, PATH_MEDIAN);
    // centre is in no contrast sum
    add_row(mk_win(0, 0, 0, 0, 255, 0, 0, 0, 0), 1'b0, 1'b1, 8'h1C, PATH_MEAN);
    add_row(mk_win(255, 255, 255, 255, 0, 255, 255, 255, 255), 1'b0, 1'b1, 8'hE2,
            PATH_MEAN);
    add_row(mk_win(8, 8, 8, 8, 16, 8, 8, 8, 8), 1'b0, 1'b0, 8'h00, PATH_MEAN);
    add_row(mk_win(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA), 1'b0,
            1'b0, 8'h00, PATH_MEAN);
    add_row(mk_win(10, 20, 30, 40, 50, 60, 70, 80, 90), 1'b0, 1'b0, 8'h00, PATH_MEAN);
    add_row(mk_win(90, 80, 70, 60, 50, 40, 30, 20, 10), 1'b0, 1'b0, 8'h00, PATH_MEAN);
    for (int i = 0; i < 4; i++)
      add_row(random_window(), 1'(i % 2), 1'b0, 8'h00, PATH_MEAN);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset threshold, then zero which must behave the same
    run_table();
    write_threshold('0);
    run_table();

    phase_thr[0] = 10'd1023;
    phase_thr[1] = 10'd765;
    phase_thr[2] = 10'd766;
    phase_thr[3] = 10'd1;
    phase_thr[4] = ThrW'($urandom_range(2, 64));
    phase_thr[5] = ThrW'($urandom_range(0, 1023));
    phase_thr[6] = ThrW'($urandom_range(64, 400));
    phase_thr[7] = 10'd30;

    for (int ph = 0; ph < 8; ph++) begin
      write_threshold(phase_thr[ph]);
      // last phase runs at full rate on both sides
      if (ph == 7) idle_en = 1'b0;
      if (ph == 1) sink_hold_req = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 3 && n == PhaseItems / 2) drain_results();
        source_gap();
        w = random_window();
        b = ($urandom_range(0, 7) == 0);
        push_window(w, b, filter_window(w, b, limit_reg));
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
